// ===== src/bnzs_pkg.sv =====
package bnzs_pkg;

  // default geometry of the bitmap
  localparam int WORD_BITS_DEF = 32;
  localparam int MAP_WORDS_DEF = 64;

  // fixed field widths
  localparam int WIDX_W        = 6;
  localparam int WDATA_W       = 32;
  localparam int IDX_W         = 12;
  // running bit base of a word may pass the 12-bit limit by up to one word
  localparam int BASE_W        = IDX_W + 1;
  // widest word the design supports
  localparam int WORD_BITS_MAX = 64;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
  } scan_res_t;

endpackage

// ===== src/bnzs_word_scan.sv =====
module bnzs_word_scan
  import bnzs_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [BASE_W-1:0]    base_i,
  input  logic [IDX_W-1:0]     start_i,
  input  logic [IDX_W-1:0]     limit_i,
  output scan_res_t            res_o
);

  localparam int PW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic [BASE_W-1:0]    start_ext;
  logic [BASE_W-1:0]    limit_ext;
  logic [BASE_W-1:0]    lo;
  logic [BASE_W-1:0]    hi;
  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] masked;
  logic [PW-1:0]        pos;

  assign start_ext = BASE_W'(start_i);
  assign limit_ext = BASE_W'(limit_i);
  assign ones      = {WORD_BITS{1'b1}};

  // bit offsets of start and limit inside this word
  assign lo = (start_ext > base_i) ? (start_ext - base_i) : '0;
  assign hi = (limit_ext > base_i) ? (limit_ext - base_i) : '0;

  // bits below start and at or past limit count as set
  assign masked = word_i | ~(ones << lo) | (ones << hi);

  always_comb begin
    pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!masked[j]) begin
        pos = PW'(j);
      end
    end
  end

  assign res_o.hit   = ~&masked;
  assign res_o.index = IDX_W'(base_i + BASE_W'(pos));

endmodule

// ===== src/bitmap_next_zero_search.sv =====
// next-zero-bit search over a word-organized bitmap
// write item: no result; start may follow in the next cycle
// search item: done_o pulses once per search, one word read a cycle
//   through the single memory read port until a zero is hit, the limit is reached or the map ends
// after reset a clearing pass zeroes the map with busy high
// done_o and zero_index_o are valid for one cycle only, the receiver cannot stall
module bitmap_next_zero_search
  import bnzs_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               opcode_i,
  input  logic [WIDX_W-1:0]  word_index_i,
  input  logic [WDATA_W-1:0] word_data_i,
  input  logic [IDX_W-1:0]   start_bit_i,
  input  logic [IDX_W-1:0]   bit_limit_i,
  output logic               done_o,
  output logic [IDX_W-1:0]   zero_index_o
);

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_SCAN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // sequencer control
  logic [AW-1:0]        addr_q, addr_d;
  logic                 issue_on_q, issue_on_d;
  logic                 chk_vld_q, chk_vld_d;
  logic                 done_q, done_d;

  // payload
  logic [BASE_W-1:0]    base_q, base_d;
  logic [BASE_W-1:0]    chk_base_q, chk_base_d;
  logic [IDX_W-1:0]     start_q, start_d;
  logic [IDX_W-1:0]     limit_q, limit_d;
  logic [IDX_W-1:0]     zero_q, zero_d;

  // bitmap memory
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;

  logic                 xfer;
  logic                 write_ok;
  logic [WORD_BITS_MAX-1:0] data_ext;
  logic [BASE_W-1:0]    base_next;
  scan_res_t            scan_res;

  assign busy = (state_q != ST_IDLE);
  assign xfer = start && !busy;

  // writes past the map are dropped, data bits above the word are dropped or zero
  assign write_ok  = (32'(word_index_i) < MAP_WORDS);
  assign data_ext  = WORD_BITS_MAX'(word_data_i);
  assign base_next = base_q + BASE_W'(WORD_BITS);

  // the single word unit: mask the word against start and limit, find its lowest zero
  bnzs_word_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word_i  (rdata_q),
    .base_i  (chk_base_q),
    .start_i (start_q),
    .limit_i (limit_q),
    .res_o   (scan_res)
  );

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    issue_on_d = issue_on_q;
    chk_vld_d  = 1'b0;
    done_d     = 1'b0;
    base_d     = base_q;
    chk_base_d = chk_base_q;
    start_d    = start_q;
    limit_d    = limit_q;
    zero_d     = zero_q;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        // zero one word a cycle
        mem_we = 1'b1;
        addr_d = addr_q + AW'(1);
        if (addr_q == AW'(MAP_WORDS - 1)) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (xfer) begin
          if (opcode_i == OP_WRITE) begin
            mem_we    = write_ok;
            mem_waddr = AW'(word_index_i);
            mem_wdata = data_ext[WORD_BITS-1:0];
          end else begin
            start_d    = start_bit_i;
            limit_d    = bit_limit_i;
            addr_d     = '0;
            base_d     = '0;
            issue_on_d = (bit_limit_i != '0);
            state_d    = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // read side: one word issued per cycle while below the limit and inside the map
        if (issue_on_q) begin
          mem_re     = 1'b1;
          chk_vld_d  = 1'b1;
          chk_base_d = base_q;
          base_d     = base_next;
          addr_d     = addr_q + AW'(1);
          issue_on_d = (addr_q != AW'(MAP_WORDS - 1)) &&
                       (base_next < BASE_W'(limit_q));
        end
        // check side: word read in the previous cycle
        if (chk_vld_q && scan_res.hit) begin
          done_d     = 1'b1;
          zero_d     = scan_res.index;
          chk_vld_d  = 1'b0;
          issue_on_d = 1'b0;
          state_d    = ST_IDLE;
        end else if (!issue_on_q && !chk_vld_q) begin
          // nothing zero in range
          done_d  = 1'b1;
          zero_d  = limit_q;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      addr_q     <= '0;
      issue_on_q <= 1'b0;
      chk_vld_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      issue_on_q <= issue_on_d;
      chk_vld_q  <= chk_vld_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    chk_base_q <= chk_base_d;
    start_q    <= start_d;
    limit_q    <= limit_d;
    zero_q     <= zero_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[addr_q];
    end
  end

  assign done_o       = done_q;
  assign zero_index_o = zero_q;

  // a result only follows a scan
  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_SCAN))
    else $error("result strobe without a scan");

  // a word is only checked after it was issued
  a_chk_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> $past(issue_on_q))
    else $error("word check without a read");

  // result never passes the limit
  a_result_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (zero_index_o <= limit_q))
    else $error("result past the limit");

  // result never lies below the start bit when the range is not empty
  a_result_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (start_q < limit_q)) |-> (zero_index_o >= start_q))
    else $error("result below the start bit");

endmodule

// ===== test/tb.sv =====
module tb;
  import bnzs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // geometry of the default build
  localparam int MAP_BITS    = WORD_BITS_DEF * MAP_WORDS_DEF;
  // generous cycle budget: every search running the whole map plus the longest gap
  localparam int CYCLE_LIMIT = 600000;
  // drain time after the last expected result
  localparam int DRAIN_CYCLES = MAP_WORDS_DEF + 8;
  localparam int RANDOM_ITEMS = 1700;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               opcode_i;
  logic [WIDX_W-1:0]  word_index_i;
  logic [WDATA_W-1:0] word_data_i;
  logic [IDX_W-1:0]   start_bit_i;
  logic [IDX_W-1:0]   bit_limit_i;
  logic               done_o;
  logic [IDX_W-1:0]   zero_index_o;

  // shadow copy of the bitmap, kept in step with every accepted write
  logic [WDATA_W-1:0] map_shadow [MAP_WORDS_DEF];
  // zero indices still owed by the block, oldest first
  logic [IDX_W-1:0]   zero_index_q [$];

  int cycle_count;
  int err_count;
  int write_count;
  int search_count;
  int match_count;

  bitmap_next_zero_search DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .word_index_i (word_index_i),
    .word_data_i  (word_data_i),
    .start_bit_i  (start_bit_i),
    .bit_limit_i  (bit_limit_i),
    .done_o       (done_o),
    .zero_index_o (zero_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               zero_index_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // first zero at or past sbit and below lim; bits beyond the map count as set
  function automatic logic [IDX_W-1:0] predict_next_zero(input int sbit, input int lim);
    logic [IDX_W-1:0] found_idx;
    logic             found;
    int               i;
    found_idx = IDX_W'(lim);
    found     = 1'b0;
    for (i = sbit; i < lim && i < MAP_BITS && !found; i++) begin
      if (map_shadow[i / WORD_BITS_DEF][i % WORD_BITS_DEF] == 1'b0) begin
        found_idx = IDX_W'(i);
        found     = 1'b1;
      end
    end
    return found_idx;
  endfunction

  // one transfer: hold start until an edge sees busy low, then book the outcome
  task automatic send_item(input logic op, input logic [WIDX_W-1:0] widx,
                           input logic [WDATA_W-1:0] wdata,
                           input logic [IDX_W-1:0] sbit, input logic [IDX_W-1:0] lim);
    @(negedge clk_i);
    start        = 1'b1;
    opcode_i     = op;
    word_index_i = widx;
    word_data_i  = wdata;
    start_bit_i  = sbit;
    bit_limit_i  = lim;
    do @(posedge clk_i); while (busy);
    if (op == OP_WRITE) begin
      map_shadow[widx] = wdata;
      write_count++;
    end else begin
      zero_index_q.push_back(predict_next_zero(int'(sbit), int'(lim)));
      search_count++;
    end
  endtask

  task automatic write_word(input logic [WIDX_W-1:0] widx, input logic [WDATA_W-1:0] wdata);
    // search fields carry noise, the block must ignore them on a write
    send_item(OP_WRITE, widx, wdata, IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic search_from(input logic [IDX_W-1:0] sbit, input logic [IDX_W-1:0] lim);
    send_item(OP_SEARCH, WIDX_W'($urandom), $urandom, sbit, lim);
  endtask

  // start held low for an idle gap set by n, none when n is zero
  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // mostly back-to-back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 70) return 0;
    else if (roll < 95) return $urandom_range(3, 1);
    else return $urandom_range(40, 10);
  endfunction

  // result checker: a strobe with nothing pending or a wrong index both fail
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (zero_index_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result zero_index=%0d", zero_index_o));
      end else begin
        if (zero_index_o !== zero_index_q[0]) begin
          report_mismatch($sformatf("zero_index got %0d expected %0d", zero_index_o,
                                    zero_index_q[0]));
        end else begin
          match_count++;
        end
        void'(zero_index_q.pop_front());
      end
    end
  end

  // map is all zero after the clearing pass, so every search stops at its start
  task automatic test_cleared_map();
    search_from(12'd0, 12'd2048);
    search_from(12'd2047, 12'd2048);
    search_from(12'd1000, 12'd4095);
    idle_gap(pick_gap());
  endtask

  // field extremes and each corner of the search
  task automatic test_directed_corners();
    // start equal to limit, start past limit, zero limit
    search_from(12'd5, 12'd5);
    search_from(12'd100, 12'd20);
    search_from(12'd0, 12'd0);
    search_from(12'd4095, 12'd0);
    // both ends of the map fully set
    write_word(6'd0, 32'hFFFF_FFFF);
    write_word(6'd63, 32'hFFFF_FFFF);
    search_from(12'd0, 12'd64);
    // limit beyond the map: bits past the end read as set
    search_from(12'd2016, 12'd4095);
    search_from(12'd4095, 12'd4095);
    // only the top bit of word 1 clear; a limit right at it hides it
    write_word(6'd1, 32'h7FFF_FFFF);
    search_from(12'd0, 12'd2048);
    search_from(12'd0, 12'd63);
    search_from(12'd0, 12'd64);
    // start inside a word with set low bits
    write_word(6'd2, 32'h0000_FFFF);
    search_from(12'd70, 12'd4095);
    // bits of the first word below the start are skipped, search spills into next word
    write_word(6'd3, 32'hFFFF_0000);
    search_from(12'd116, 12'd4095);
    // alternating index and data bits
    write_word(6'd42, 32'hAAAA_AAAA);
    write_word(6'd21, 32'h5555_5555);
    search_from(12'd1344, 12'd1376);
    search_from(12'd673, 12'd700);
    write_word(6'd4, 32'h0000_0000);
    search_from(12'd127, 12'd129);
    idle_gap(pick_gap());
  endtask

  // dense map with sparse holes so that searches walk many words
  task automatic test_random_traffic();
    logic [IDX_W-1:0] sbit;
    logic [IDX_W-1:0] lim;
    logic [WDATA_W-1:0] wdata;
    int               roll;
    int               n;
    bit               burst;
    burst = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate stretches of back-to-back traffic with gappy ones
      if (n % 64 == 0) burst = ($urandom_range(3, 0) == 0);
      if ($urandom_range(99, 0) < 30) begin
        roll = $urandom_range(99, 0);
        if (roll < 55) wdata = 32'hFFFF_FFFF;
        else if (roll < 85) wdata = ~(32'h1 << $urandom_range(31, 0));
        else if (roll < 95) wdata = $urandom;
        else wdata = 32'h0;
        write_word(WIDX_W'($urandom_range(63, 0)), wdata);
      end else begin
        roll = $urandom_range(99, 0);
        if (roll < 55) begin
          sbit = IDX_W'($urandom_range(MAP_BITS - 1, 0));
          lim  = IDX_W'($urandom_range(MAP_BITS, int'(sbit)));
        end else if (roll < 70) begin
          // limit past the end of the map
          sbit = IDX_W'($urandom_range(MAP_BITS - 1, 0));
          lim  = IDX_W'($urandom_range(4095, MAP_BITS));
        end else if (roll < 80) begin
          // empty range
          lim  = IDX_W'($urandom_range(4095, 0));
          sbit = IDX_W'($urandom_range(4095, int'(lim)));
        end else if (roll < 90) begin
          // short window around a word boundary
          sbit = IDX_W'($urandom_range(63, 0) * WORD_BITS_DEF + $urandom_range(3, 0) - 2);
          lim  = sbit + IDX_W'($urandom_range(40, 0));
        end else begin
          sbit = IDX_W'($urandom);
          lim  = IDX_W'($urandom);
        end
        search_from(sbit, lim);
      end
      if (!burst) idle_gap(pick_gap());
    end
  endtask

  initial begin
    int k;
    cycle_count  = 0;
    err_count    = 0;
    write_count  = 0;
    search_count = 0;
    match_count  = 0;
    for (k = 0; k < MAP_WORDS_DEF; k++) map_shadow[k] = '0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    opcode_i     = OP_WRITE;
    word_index_i = '0;
    word_data_i  = '0;
    start_bit_i  = '0;
    bit_limit_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_cleared_map();
    test_directed_corners();
    test_random_traffic();

    @(negedge clk_i);
    start = 1'b0;
    // every owed result, then a quiet window for stray strobes
    while (zero_index_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d word writes and %0d searches, %0d results matched, in %0d cycles",
             write_count, search_count, match_count, cycle_count);
    $display("searches spanned empty ranges, limits past the map and dense sparse-hole maps");
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bnzs_pkg.sv
src/bnzs_word_scan.sv
src/bitmap_next_zero_search.sv
test/tb.sv
